[hw/rtl/spn_pkg.sv]
package spn_pkg;

  localparam int unsigned NumCells = 4;
  localparam int unsigned NumKeys  = 5;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  stage_t;
  typedef word_t [NumKeys-1:0] key_set_t;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  // One beat as it travels down the chain
  typedef struct packed {
    op_e   op;
    word_t data;
  } beat_t;

  localparam stage_t FirstStage = 2'd0;
  localparam stage_t LastStage  = 2'd3;

  localparam word_t MasterKeyReset = 32'h6131_6539;

  localparam logic [3:0] SboxFwd [16] = '{
    4'h6, 4'h4, 4'hC, 4'h5, 4'h0, 4'h7, 4'h2, 4'hE,
    4'h1, 4'hF, 4'h3, 4'hD, 4'h8, 4'hA, 4'h9, 4'hB
  };

  localparam logic [3:0] SboxInv [16] = '{
    4'h4, 4'h8, 4'h6, 4'hA, 4'h1, 4'h3, 4'h0, 4'h5,
    4'hC, 4'hE, 4'hD, 4'hF, 4'h2, 4'hB, 4'h7, 4'h9
  };

  // Nibble substitution over the whole word
  function automatic word_t sub_nibbles(word_t v, logic inv);
    word_t r;
    r = '0;
    for (int n = 0; n < 8; n++) begin
      if (inv) begin
        r[4*n +: 4] = SboxInv[v[4*n +: 4]];
      end else begin
        r[4*n +: 4] = SboxFwd[v[4*n +: 4]];
      end
    end
    return r;
  endfunction

  // 4x4 bit-matrix transpose of one byte pair, row 0 = msb nibble
  function automatic logic [15:0] transpose16(logic [15:0] w);
    logic [15:0] r;
    r = '0;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        r[15 - (4*row + col)] = w[15 - (4*col + row)];
      end
    end
    return r;
  endfunction

  function automatic word_t transpose_pairs(word_t v);
    return {transpose16(v[31:16]), transpose16(v[15:0])};
  endfunction

  // f(a,b) = ((a & 3) << 6) | (b << 2)
  function automatic logic [7:0] mix_byte(logic [3:0] a, logic [3:0] b);
    return {a[1:0], b, 2'b00};
  endfunction

  function automatic word_t next_key(word_t k);
    return {mix_byte(k[31:28], k[23:20]), mix_byte(k[27:24], k[19:16]),
            mix_byte(k[15:12], k[7:4]),   mix_byte(k[11:8],  k[3:0])};
  endfunction

  function automatic word_t last_key(word_t k);
    return {mix_byte(k[31:28], k[27:24]), mix_byte(k[23:20], k[19:16]),
            mix_byte(k[15:12], k[11:8]),  mix_byte(k[7:4],   k[3:0])};
  endfunction

endpackage

[hw/rtl/spn_key_sched.sv]
module spn_key_sched (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  spn_pkg::word_t    cfg_wdata_i,
  output spn_pkg::key_set_t keys_o
);
  import spn_pkg::*;

  word_t master_key_q;

  // Master key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_key_q <= MasterKeyReset;
    end else if (cfg_we_i) begin
      master_key_q <= cfg_wdata_i;
    end
  end

  // Keys follow master key; user changes it only while chain empty, unchecked
  always_comb begin
    keys_o[0] = master_key_q;
    keys_o[1] = next_key(keys_o[0]);
    keys_o[2] = next_key(keys_o[1]);
    keys_o[3] = next_key(keys_o[2]);
    keys_o[4] = last_key(keys_o[3]);
  end

endmodule

[hw/rtl/spn_round_cell.sv]
module spn_round_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spn_pkg::stage_t   stage_i,
  input  spn_pkg::key_set_t keys_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  spn_pkg::beat_t    beat_i,
  output logic              valid_o,
  input  logic              ready_i,
  output spn_pkg::beat_t    beat_o
);
  import spn_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q, beat_d;
  logic  is_dec;
  word_t pre, mid, rkey;
  logic  [2:0] key_idx;

  assign is_dec = (beat_i.op == OP_DEC);

  // Cell takes a beat when empty or when its own beat leaves
  assign ready_o = !valid_q || ready_i;

  // Round datapath: first-cell whitening, S-box/transpose (dec reversed), key
  always_comb begin
    pre = beat_i.data;
    if (stage_i == FirstStage) begin
      pre = beat_i.data ^ (is_dec ? keys_i[4] : keys_i[0]);
    end
    if (is_dec) begin
      key_idx = 3'd3 - {1'b0, stage_i};
      mid = (stage_i != FirstStage) ? transpose_pairs(pre) : pre;
      mid = sub_nibbles(mid, 1'b1);
    end else begin
      key_idx = {1'b0, stage_i} + 3'd1;
      mid = sub_nibbles(pre, 1'b0);
      mid = (stage_i != LastStage) ? transpose_pairs(mid) : mid;
    end
    rkey        = keys_i[key_idx];
    beat_d.op   = beat_i.op;
    beat_d.data = mid ^ rkey;
  end

  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  // A held beat stays put until taken downstream
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(beat_q))
    else $error("cell dropped or changed a stalled beat");

  // A beat taken in lands in the register
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o && valid_i |=> valid_q)
    else $error("cell lost an accepted beat");

  // An empty cell never holds off its upstream neighbor
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> ready_o)
    else $error("empty cell not ready");

  // A cell that hands its beat on and takes none in goes empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !(valid_i && ready_o) && ready_i |=> !valid_q)
    else $error("cell kept a beat it handed on");

endmodule

[hw/rtl/toy_spn_block_cipher_32.sv]
// Toy 32-bit SPN cipher. One block per beat, encrypt (operation_i = 0) or decrypt
// (operation_i = 1), under the key written through cfg_we_i / cfg_wdata_i (reset key
// 0x61316539). The rounds run down a chain of four registered cells, one round each,
// so a block accepted into the first cell moves through the second, third and fourth
// cell registers to block_out_o, and a new block can be taken every cycle unless the
// chain is stalled; each cell holds its beat under backpressure and empty cells keep
// accepting. Write the key only while no beat is in flight.
module toy_spn_block_cipher_32 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [31:0]         block_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         block_out_o
);
  import spn_pkg::*;

  key_set_t keys;
  logic     [NumCells:0] valid;
  logic     [NumCells:0] ready;
  beat_t    beat [NumCells+1];

  spn_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .keys_o      (keys)
  );

  // Input beat enters the head of the chain
  assign valid[0]     = in_valid_i;
  assign in_ready_o   = ready[0];
  assign beat[0].op   = op_e'(operation_i);
  assign beat[0].data = block_in_i;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    spn_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage_t'(g)),
      .keys_i  (keys),
      .valid_i (valid[g]),
      .ready_o (ready[g]),
      .beat_i  (beat[g]),
      .valid_o (valid[g+1]),
      .ready_i (ready[g+1]),
      .beat_o  (beat[g+1])
    );
  end

  // Last cell register is the output register
  assign ready[NumCells] = out_ready_i;
  assign out_valid_o     = valid[NumCells];
  assign block_out_o     = beat[NumCells].data;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import spn_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 165;
  localparam int unsigned NumRows     = 20;
  localparam int unsigned MaxReports  = 10;

  // Forward nibble substitution; the inverse is found by search
  localparam logic [3:0] SubFwd [16] = '{
    4'h6, 4'h4, 4'hC, 4'h5, 4'h0, 4'h7, 4'h2, 4'hE,
    4'h1, 4'hF, 4'h3, 4'hD, 4'h8, 4'hA, 4'h9, 4'hB
  };

  // One directed row: key in force, operation, block, optional known result
  typedef struct packed {
    word_t key;
    op_e   op;
    word_t data;
    logic  typed;
    word_t result;
  } stim_row_t;

  stim_row_t directed_rows [NumRows] = '{
    // reset key, extreme and patterned blocks
    '{MasterKeyReset, OP_ENC, 32'h0000_0000, 1'b0, 32'h0},
    '{MasterKeyReset, OP_ENC, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{MasterKeyReset, OP_DEC, 32'h0000_0000, 1'b0, 32'h0},
    '{MasterKeyReset, OP_DEC, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{MasterKeyReset, OP_ENC, 32'h8000_0000, 1'b0, 32'h0},
    '{MasterKeyReset, OP_DEC, 32'h0000_0001, 1'b0, 32'h0},
    '{MasterKeyReset, OP_ENC, 32'hA5A5_5A5A, 1'b0, 32'h0},
    // all-zero key: every round key is zero
    '{32'h0000_0000, OP_ENC, 32'h0000_0000, 1'b1, 32'h20B2_20B2},
    '{32'h0000_0000, OP_DEC, 32'h20B2_20B2, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, OP_ENC, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'h0000_0000, OP_DEC, 32'hFFFF_FFFF, 1'b0, 32'h0},
    // all-ones key
    '{32'hFFFF_FFFF, OP_ENC, 32'h0000_0000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, OP_DEC, 32'h0000_0000, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, OP_ENC, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, OP_DEC, 32'h0F0F_0F0F, 1'b0, 32'h0},
    '{32'h8000_0001, OP_ENC, 32'h1234_5678, 1'b0, 32'h0},
    '{32'h8000_0001, OP_DEC, 32'h89AB_CDEF, 1'b0, 32'h0},
    '{32'h5A3C_96E1, OP_ENC, 32'h0123_4567, 1'b0, 32'h0},
    '{32'h5A3C_96E1, OP_DEC, 32'hFEDC_BA98, 1'b0, 32'h0},
    '{32'h5A3C_96E1, OP_ENC, 32'h0000_0001, 1'b0, 32'h0}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  word_t cfg_wdata = '0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  op_e   operation = OP_ENC;
  word_t block_in = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t block_out;

  // Key the block holds, tracked on the bench side
  word_t cipher_key = MasterKeyReset;
  // Results still owed by the block, oldest first
  word_t pending_blocks [$];
  logic  typed_valid = 1'b0;
  word_t typed_value = '0;

  logic  send_idle_on = 1'b1;
  logic  recv_idle_on = 1'b1;
  logic  hold_request = 1'b0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  toy_spn_block_cipher_32 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .block_in_i  (block_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .block_out_o (block_out)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------
  function automatic logic [3:0] sub_nibble(logic [3:0] x, logic inv);
    logic [3:0] r;
    r = SubFwd[x];
    if (inv) begin
      for (int i = 0; i < 16; i++) begin
        if (SubFwd[i] == x) r = 4'(i);
      end
    end
    return r;
  endfunction

  function automatic word_t spn_sub(word_t v, logic inv);
    word_t r;
    for (int n = 0; n < 8; n++) begin
      r[4*n +: 4] = sub_nibble(v[4*n +: 4], inv);
    end
    return r;
  endfunction

  // 4x4 bit matrix, row 0 in the top nibble, column 0 at the nibble msb
  function automatic logic [15:0] flip_matrix(logic [15:0] m);
    logic [3:0]  rows [4];
    logic [15:0] t;
    for (int r = 0; r < 4; r++) begin
      rows[r] = m[15-4*r -: 4];
    end
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[15-4*c-r] = rows[r][3-c];
      end
    end
    return t;
  endfunction

  function automatic word_t flip_pair(word_t v);
    return {flip_matrix(v[31:16]), flip_matrix(v[15:0])};
  endfunction

  function automatic logic [7:0] key_mix(logic [3:0] a, logic [3:0] b);
    return ((8'(a) & 8'h03) << 6) | (8'(b) << 2);
  endfunction

  // Round keys 1..3: nibbles of each byte pair are combined across the pair
  function automatic word_t key_next(word_t k);
    word_t r;
    for (int h = 0; h < 2; h++) begin
      r[31-16*h -: 8] = key_mix(k[31-16*h -: 4], k[23-16*h -: 4]);
      r[23-16*h -: 8] = key_mix(k[27-16*h -: 4], k[19-16*h -: 4]);
    end
    return r;
  endfunction

  // Round key 4: nibbles of each byte combined within the byte
  function automatic word_t key_last(word_t k);
    word_t r;
    for (int b = 0; b < 4; b++) begin
      r[31-8*b -: 8] = key_mix(k[31-8*b -: 4], k[27-8*b -: 4]);
    end
    return r;
  endfunction

  function automatic word_t spn_cipher(op_e op, word_t blk, word_t key);
    word_t rk [5];
    word_t v;
    rk[0] = key;
    for (int r = 1; r < 4; r++) begin
      rk[r] = key_next(rk[r-1]);
    end
    rk[4] = key_last(rk[3]);
    v = blk;
    if (op == OP_ENC) begin
      v = v ^ rk[0];
      for (int r = 1; r < 4; r++) begin
        v = flip_pair(spn_sub(v, 1'b0)) ^ rk[r];
      end
      v = spn_sub(v, 1'b0) ^ rk[4];
    end else begin
      v = spn_sub(v ^ rk[4], 1'b1) ^ rk[3];
      for (int r = 2; r >= 0; r--) begin
        v = spn_sub(flip_pair(v), 1'b1) ^ rk[r];
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------
  // Input side: offer one beat, return at the falling edge after it
  // was taken, with valid still high
  // ---------------------------------------------------------------
  task automatic send_block(input op_e op, input word_t data, input logic typed,
                            input word_t result);
    while (send_idle_on && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    block_in    <= data;
    typed_valid = typed;
    typed_value = result;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Key change only with nothing in flight
  task automatic load_key(input word_t k);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we     <= 1'b0;
    cipher_key = k;
  endtask

  // Predict each accepted beat
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_blocks.push_back(typed_valid ? typed_value
                                           : spn_cipher(operation, block_in, cipher_key));
    end
  end

  // Check each delivered beat against the oldest prediction
  always @(posedge clk) begin : out_check
    word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_blocks.size() == 0) begin
        error_cnt++;
        if (error_cnt <= MaxReports) begin
          $display("unexpected result: block_out %08h", block_out);
        end
      end else begin
        want = pending_blocks.pop_front();
        if (block_out !== want) begin
          error_cnt++;
          if (error_cnt <= MaxReports) begin
            $display("mismatch: block_out expected %08h got %08h", want, block_out);
          end
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_ready <= !(recv_idle_on && $urandom_range(0, 99) < 17);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  initial begin : stimulus
    op_e         op;
    word_t       data;
    word_t       phase_key;
    word_t       last_cipher;
    logic        have_cipher;
    int unsigned sel;

    last_cipher = '0;
    have_cipher = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows
    for (int i = 0; i < NumRows; i++) begin
      if (directed_rows[i].key != cipher_key) begin
        load_key(directed_rows[i].key);
      end
      send_block(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                 directed_rows[i].result);
    end

    // Random phases, one key each
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       phase_key = 32'hFFFF_FFFF;
        1:       phase_key = 32'h0000_0000;
        3:       phase_key = MasterKeyReset;
        5:       phase_key = 32'h0000_0001;
        6:       phase_key = 32'h8000_0000;
        default: phase_key = $urandom();
      endcase
      load_key(phase_key);
      have_cipher  = 1'b0;
      // phase 3 runs back to back on both sides
      send_idle_on = (p != 3);
      recv_idle_on = (p != 3);
      if (p == 0) begin
        hold_request = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        sel = $urandom_range(0, 15);
        if (sel < 3 && have_cipher) begin
          // decrypt what was just enciphered
          op   = OP_DEC;
          data = last_cipher;
        end else begin
          op = op_e'($urandom_range(0, 1));
          if (sel == 3) begin
            case ($urandom_range(0, 3))
              0:       data = 32'h0000_0000;
              1:       data = 32'hFFFF_FFFF;
              2:       data = 32'h1 << $urandom_range(0, 31);
              default: data = ~(32'h1 << $urandom_range(0, 31));
            endcase
          end else begin
            data = $urandom();
          end
        end
        if (op == OP_ENC) begin
          last_cipher = spn_cipher(op, data, cipher_key);
          have_cipher = 1'b1;
        end
        send_block(op, data, 1'b0, '0);
      end
    end

    // Drain
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    if (error_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
